// ===== hw/rtl/ddq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package ddq_pkg;

   localparam int OP_W     = 3;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_LEFT  = 3'd0,
      OP_PUSH_RIGHT = 3'd1,
      OP_POP_LEFT   = 3'd2,
      OP_POP_RIGHT  = 3'd3,
      OP_READ       = 3'd4,
      OP_WRITE      = 3'd5,
      OP_CLEAR      = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic accept;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

// ===== hw/rtl/ddq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddq_req_if / ddq_rsp_if
// Valid/ready channels for queue requests and responses.
// ----------------------------------------------------------------------------
interface ddq_req_if;
   logic                             valid;
   logic                             ready;
   logic [ddq_pkg::OP_W-1:0]         opcode;
   logic signed [ddq_pkg::DATA_W-1:0] data_in;
   logic [ddq_pkg::POS_W-1:0]        position;

   modport source (output valid, output opcode, output data_in, output position,
                   input ready);
   modport sink   (input valid, input opcode, input data_in, input position,
                   output ready);
endinterface

interface ddq_rsp_if #(parameter int CNT_W = 5);
   logic                               valid;
   logic                               ready;
   logic signed [ddq_pkg::DATA_W-1:0]  data_out;
   logic [ddq_pkg::STATUS_W-1:0]       status;
   logic [CNT_W-1:0]                   count;

   modport source (output valid, output data_out, output status, output count,
                   input ready);
   modport sink   (input valid, input data_out, input status, input count,
                   output ready);
endinterface

// ===== hw/rtl/ddq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ddq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ddq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddq_ctrl
// Request sequencer: accept, wait for read data and a free output slot, load.
// ----------------------------------------------------------------------------
module ddq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ddq_pkg::dp_stat_type dp_stat,
   output ddq_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.load   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the output register can take the response
            if (dp_stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == S_EXEC)
      else $error("accepted request did not enter execute");

   a_load_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_IDLE)
      else $error("load did not return to idle");

   a_no_accept_and_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.load))
      else $error("accept and load in the same cycle");

endmodule

// ===== hw/rtl/ddq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddq_datapath
// Ring pointers, fill count, slot RAM and response register.
// ----------------------------------------------------------------------------
module ddq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ddq_pkg::cmd_type                   cmd,
   output ddq_pkg::dp_stat_type               dp_stat,
   input  logic [ddq_pkg::OP_W-1:0]           req_opcode,
   input  logic signed [ddq_pkg::DATA_W-1:0]  req_data_in,
   input  logic [ddq_pkg::POS_W-1:0]          req_position,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic signed [ddq_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [ddq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = ((CNT_W > ddq_pkg::POS_W) ? CNT_W : ddq_pkg::POS_W) + 1;

   logic [PTR_W-1:0]             left_ff, left_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   ddq_pkg::status_type          st_ff, st_in;
   logic                         rd_sel_ff, rd_sel_in;
   logic                         out_valid_ff, out_valid_in;
   logic [ddq_pkg::DATA_W-1:0]   data_out_ff;
   ddq_pkg::status_type          status_out_ff;
   logic [CNT_W-1:0]             count_out_ff;

   logic                         full, empty, out_of_range;
   logic [SUM_W-1:0]             offset, slot_sum, slot_wrap, pos_ext;
   logic [PTR_W-1:0]             slot, left_dec;
   logic                         ram_wr_en, ram_rd_en;
   logic [PTR_W-1:0]             ram_addr;
   logic [ddq_pkg::DATA_W-1:0]   ram_rd_data;

   assign full         = count_ff == CNT_W'(DEPTH);
   assign empty        = count_ff == '0;
   assign pos_ext      = SUM_W'(req_position);
   assign out_of_range = pos_ext >= SUM_W'(count_ff);
   assign left_dec     = (left_ff == '0) ? PTR_W'(DEPTH - 1) : left_ff - PTR_W'(1);

   // offset from the left end for the slot being addressed, or for the new left end on a left pop
   always_comb begin
      case (req_opcode)
         ddq_pkg::OP_PUSH_RIGHT: offset = SUM_W'(count_ff);
         ddq_pkg::OP_POP_LEFT:   offset = SUM_W'(1);
         ddq_pkg::OP_POP_RIGHT:  offset = SUM_W'(count_ff) - SUM_W'(1);
         default:                offset = pos_ext;
      endcase
   end

   assign slot_sum  = SUM_W'(left_ff) + offset;
   assign slot_wrap = (slot_sum >= SUM_W'(DEPTH)) ? slot_sum - SUM_W'(DEPTH) : slot_sum;
   assign slot      = slot_wrap[PTR_W-1:0];

   always_comb begin
      left_in   = left_ff;
      count_in  = count_ff;
      st_in     = st_ff;
      rd_sel_in = rd_sel_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      ram_addr  = slot;
      if (cmd.accept) begin
         st_in     = ddq_pkg::ST_OK;
         rd_sel_in = 1'b0;
         case (req_opcode)
            ddq_pkg::OP_PUSH_LEFT: begin
               if (full) begin
                  st_in = ddq_pkg::ST_FULL;
               end else begin
                  ram_wr_en = 1'b1;
                  ram_addr  = left_dec;
                  left_in   = left_dec;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            ddq_pkg::OP_PUSH_RIGHT: begin
               if (full) begin
                  st_in = ddq_pkg::ST_FULL;
               end else begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            ddq_pkg::OP_POP_LEFT: begin
               if (empty) begin
                  st_in = ddq_pkg::ST_EMPTY;
               end else begin
                  ram_rd_en = 1'b1;
                  rd_sel_in = 1'b1;
                  ram_addr  = left_ff;
                  left_in   = slot;
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            ddq_pkg::OP_POP_RIGHT: begin
               if (empty) begin
                  st_in = ddq_pkg::ST_EMPTY;
               end else begin
                  ram_rd_en = 1'b1;
                  rd_sel_in = 1'b1;
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            ddq_pkg::OP_READ: begin
               if (empty) begin
                  st_in = ddq_pkg::ST_EMPTY;
               end else if (out_of_range) begin
                  st_in = ddq_pkg::ST_RANGE;
               end else begin
                  ram_rd_en = 1'b1;
                  rd_sel_in = 1'b1;
               end
            end
            ddq_pkg::OP_WRITE: begin
               if (empty) begin
                  st_in = ddq_pkg::ST_EMPTY;
               end else if (out_of_range) begin
                  st_in = ddq_pkg::ST_RANGE;
               end else begin
                  ram_wr_en = 1'b1;
               end
            end
            ddq_pkg::OP_CLEAR: begin
               left_in  = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   ddq_ram #(
      .WIDTH (ddq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (req_data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   assign dp_stat.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff     <= st_in;
      rd_sel_ff <= rd_sel_in;
      if (cmd.load) begin
         data_out_ff   <= rd_sel_ff ? ram_rd_data : '0;
         status_out_ff <= st_ff;
         count_out_ff  <= count_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_data_out = data_out_ff;
   assign rsp_status   = status_out_ff;
   assign rsp_count    = count_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_ram_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("RAM read and write in one request");

   a_zero_without_read: assert property (@(posedge clock) disable iff (reset)
      cmd.load && !rd_sel_ff |=> rsp_data_out == '0)
      else $error("nonzero data on a response without a read");

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of 32-bit words held in a ring-buffer RAM.
// Response: valid is set in the output register when the request leaves execute,
// held off while the previous response waits on rsp ready.
// Requests: a new request is not taken until the current one has left execute.
// Reset: clears pointer, fill count and response valid; RAM is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   ddq_req_if.sink     req_chan,
   ddq_rsp_if.source   rsp_chan
);

   ddq_pkg::cmd_type     cmd;
   ddq_pkg::dp_stat_type dp_stat;
   logic                 req_ready;

   ddq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   ddq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .dp_stat      (dp_stat),
      .req_opcode   (req_chan.opcode),
      .req_data_in  (req_chan.data_in),
      .req_position (req_chan.position),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_data_out (rsp_chan.data_out),
      .rsp_status   (rsp_chan.status),
      .rsp_count    (rsp_chan.count)
   );

   assign req_chan.ready = req_ready;

endmodule
